### hw/rtl/cmp_pkg.sv
// Package for complex_magnitude_phase: widths, constants and shared types.
// Used by every module in hw/rtl; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package cmp_pkg;
    localparam int SampleBits = 16;
    localparam int FracBits   = 13;
    localparam int AbsBits    = SampleBits;
    localparam int SqBits     = 2 * AbsBits;
    localparam int SumBits    = SqBits + 1;
    localparam int MagBits    = AbsBits + 1;
    localparam int NumBits    = SqBits + 5;
    localparam int DenBits    = SqBits + 5;
    localparam int QBits      = FracBits + 1;
    localparam int PhaseBits  = 16;
    localparam int MagOutBits = 16;
    localparam int WideBits   = FracBits + 4;
    localparam logic signed [WideBits-1:0] PiQ   = WideBits'(25736);
    localparam logic signed [WideBits-1:0] HalfQ = WideBits'(12868);

    typedef struct packed {
        logic re_zero;
        logic im_zero;
        logic re_neg;
        logic im_neg;
        logic small_z;
    } quad_t;
endpackage
`default_nettype wire

### hw/rtl/complex_magnitude_phase.sv
// Top level of complex_magnitude_phase: input stages, square root and divider
// pipelines, phase assembly and output register. Depends on cmp_pkg, cmp_sqrt, cmp_div.
`timescale 1ns / 1ps
`default_nettype none
// Converts one complex sample (signed 16-bit real and imaginary parts) to polar
// form: magnitude = floor(sqrt(re^2+im^2)) and phase = fast rational atan2
// approximation (coefficient 0.28) in Q3.13 radians with quadrant corrections.
// The block accepts one request every clock cycle while the output is not
// stalled. From input acceptance to output valid a sample passes the stages for
// absolute values, products, and the numerator, denominator and radicand, then seventeen stages of the square
// root (one result bit each), which also cover the fourteen-stage divider, and
// the output register. The whole pipeline advances only when its last stage can
// move, so backpressure stalls everything without loss or repetition.
module complex_magnitude_phase
    import cmp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // [15:0] re_part, [31:16] im_part
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata   // [15:0] magnitude, [31:16] phase_angle
);
    localparam int Lat = MagBits + 4;

    logic en;
    logic [Lat-1:0] vld_reg;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[Lat-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[Lat-2:0], s_tvalid};
    end

    // Stage 1: absolute values and signs.
    logic signed [SampleBits-1:0] re_in, im_in;
    assign re_in = s_tdata[15:0];
    assign im_in = s_tdata[31:16];
    logic [AbsBits-1:0] are_reg, aim_reg;
    quad_t q1_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            are_reg <= re_in[SampleBits-1] ? AbsBits'(-re_in) : AbsBits'(re_in);
            aim_reg <= im_in[SampleBits-1] ? AbsBits'(-im_in) : AbsBits'(im_in);
            q1_reg.re_zero <= (re_in == '0);
            q1_reg.im_zero <= (im_in == '0);
            q1_reg.re_neg  <= re_in[SampleBits-1];
            q1_reg.im_neg  <= im_in[SampleBits-1];
            q1_reg.small_z <= 1'b0;
        end
    end

    // Stage 2: products.
    logic [SqBits-1:0] re2_reg, im2_reg, rim_reg;
    quad_t q2_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            re2_reg <= are_reg * are_reg;
            im2_reg <= aim_reg * aim_reg;
            rim_reg <= are_reg * aim_reg;
            q2_reg  <= {q1_reg.re_zero, q1_reg.im_zero, q1_reg.re_neg, q1_reg.im_neg,
                        aim_reg < are_reg};
        end
    end

    // Stage 3: numerator, denominator and radicand.
    logic [NumBits-1:0] num_reg;
    logic [DenBits-1:0] den_reg;
    logic [SumBits-1:0] sum_reg;
    quad_t q3_reg;
    logic [DenBits-1:0] big_sq, sml_sq;
    assign big_sq = q2_reg.small_z ? DenBits'(re2_reg) : DenBits'(im2_reg);
    assign sml_sq = q2_reg.small_z ? DenBits'(im2_reg) : DenBits'(re2_reg);
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= NumBits'(rim_reg) * NumBits'(25);
            den_reg <= (q2_reg.re_zero && q2_reg.im_zero) ? DenBits'(1)
                     : big_sq * DenBits'(25) + sml_sq * DenBits'(7);
            sum_reg <= SumBits'(re2_reg) + SumBits'(im2_reg);
            q3_reg  <= q2_reg;
        end
    end

    // Divider and square root pipelines, sign info delayed alongside.
    logic [QBits-1:0]   term;
    logic [MagBits-1:0] root;
    cmp_div u_div (.clk(clk), .en(en), .num(num_reg), .den(den_reg), .term(term));
    cmp_sqrt u_sqrt (.clk(clk), .en(en), .radicand(sum_reg), .root(root));

    // The divider finishes earlier than the square root, so its quotient passes
    // through delay registers to line up with the root.
    localparam int DivLat  = QBits;
    localparam int SqrtLat = MagBits;
    localparam int DivPad  = SqrtLat - DivLat;
    quad_t q_dly_reg [SqrtLat];
    logic [QBits-1:0] term_dly_reg [DivPad];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_dly_reg[0] <= q3_reg;
            for (int i = 1; i < SqrtLat; i++)
                q_dly_reg[i] <= q_dly_reg[i-1];
            term_dly_reg[0] <= term;
            for (int i = 1; i < DivPad; i++)
                term_dly_reg[i] <= term_dly_reg[i-1];
        end
    end

    // Phase assembly and output register.
    quad_t qf;
    logic [QBits-1:0] term_f;
    logic signed [WideBits-1:0] t_s, ph;
    always_comb
    begin
        qf     = q_dly_reg[SqrtLat-1];
        term_f = term_dly_reg[DivPad-1];
        t_s = (qf.re_neg != qf.im_neg) ? -WideBits'(term_f) : WideBits'(term_f);
        if (qf.re_zero)
            ph = qf.im_zero ? '0 : (qf.im_neg ? -HalfQ : HalfQ);
        else if (qf.small_z)
        begin
            ph = t_s;
            if (qf.re_neg)
                ph = qf.im_neg ? ph - PiQ : ph + PiQ;
        end
        else
        begin
            ph = HalfQ - t_s;
            if (qf.im_neg)
                ph = ph - PiQ;
        end
    end

    logic [MagOutBits-1:0] mag_reg;
    logic [PhaseBits-1:0]  ph_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= MagOutBits'(root);
            ph_reg  <= PhaseBits'(ph);
        end
    end
    assign m_tdata = {ph_reg, mag_reg};
endmodule
`default_nettype wire

### hw/rtl/cmp_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on cmp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cmp_sqrt
    import cmp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [SumBits-1:0] radicand,
    output logic      [MagBits-1:0] root
);
    logic [SumBits-1:0] rem_reg  [MagBits+1];
    logic [MagBits-1:0] root_reg [MagBits+1];
    assign rem_reg[0]  = radicand;
    assign root_reg[0] = '0;
    for (genvar s = 0; s < MagBits; s++) begin : g_stage
        localparam int B = MagBits - 1 - s;
        logic [SumBits+1:0] trial;
        logic [SumBits+1:0] rem_w;
        logic [MagBits-1:0] rt_next;
        always_comb
        begin
            trial   = ((SumBits+2)'(root_reg[s]) << (B + 1)) + ((SumBits+2)'(1) << (2 * B));
            rem_w   = (SumBits+2)'(rem_reg[s]);
            rt_next = root_reg[s];
            if (rem_w >= trial)
            begin
                rem_w   = rem_w - trial;
                rt_next = rt_next | (MagBits'(1) << B);
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1]  <= rem_w[SumBits-1:0];
                root_reg[s+1] <= rt_next;
            end
        end
    end
    assign root = root_reg[MagBits];
endmodule
`default_nettype wire

### hw/rtl/cmp_div.sv
// Pipelined restoring divider giving round(2^F*p/d) with ties up, p < d.
// Depends on cmp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cmp_div
    import cmp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [NumBits-1:0] num,
    input  wire logic [DenBits-1:0] den,
    output logic      [QBits-1:0]   term
);
    logic [DenBits:0]   rem_reg [QBits+1];
    logic [DenBits-1:0] den_reg [QBits+1];
    logic [QBits:0]     q_reg   [QBits+1];
    assign rem_reg[0] = (DenBits+1)'(num);
    assign den_reg[0] = den;
    assign q_reg[0]   = '0;
    for (genvar s = 0; s < QBits; s++) begin : g_stage
        logic [DenBits+1:0] sh;
        logic [DenBits:0]   r_n;
        logic [QBits:0]     q_n;
        always_comb
        begin
            sh  = {rem_reg[s], 1'b0};
            q_n = {q_reg[s][QBits-1:0], 1'b0};
            r_n = sh[DenBits:0];
            if (sh >= (DenBits+2)'(den_reg[s]))
            begin
                r_n    = (DenBits+1)'(sh - (DenBits+2)'(den_reg[s]));
                q_n[0] = 1'b1;
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1] <= r_n;
                den_reg[s+1] <= den_reg[s];
                q_reg[s+1]   <= q_n;
            end
        end
    end
    logic [QBits+1:0] rnd;
    assign rnd  = (QBits+2)'(q_reg[QBits]) + (QBits+2)'(1);
    assign term = rnd[QBits:1];
endmodule
`default_nettype wire

### dv/cmp_checker.sv
// Checker for complex_magnitude_phase: watches both stream channels, predicts
// magnitude and phase for each accepted request and compares in order.
// Depends on nothing but the block's port widths.
`timescale 1ns / 1ps
module cmp_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    output int               fail_count,
    output int               pending_count
);
    localparam int PhaseFrac = 13;
    localparam logic [63:0] PiQ60 = 64'h3243F6A8885A308D;

    typedef struct packed {
        logic signed [15:0] phase_angle;
        logic [15:0]        magnitude;
    } polar_t;

    polar_t polar_queue[$];

    function automatic longint pi_fixed(input int extra);
        int sh;
        sh = 60 - PhaseFrac + extra;
        return longint'((PiQ60 + (64'd1 << (sh - 1))) >> sh);
    endfunction

    function automatic longint rational_term(input longint unsigned num,
                                             input longint unsigned den);
        longint unsigned rem;
        longint unsigned quo;
        rem = num;
        quo = 0;
        for (int i = 0; i <= PhaseFrac; i++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | 1;
            end
        end
        return longint'((quo + 1) >> 1);
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned root;
        longint unsigned probe;
        root = 0;
        probe = 64'd1 << 62;
        while (probe > x)
            probe = probe >> 2;
        while (probe != 0) begin
            if (x >= root + probe) begin
                x = x - (root + probe);
                root = (root >> 1) + probe;
            end
            else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic polar_t to_polar(input logic signed [15:0] re,
                                        input logic signed [15:0] im);
        longint unsigned are;
        longint unsigned aim;
        longint unsigned mag;
        longint ph;
        longint term;
        longint pi_q;
        longint half_q;
        logic neg;
        polar_t res;
        are = (re < 0) ? longint'(-longint'(re)) : longint'(re);
        aim = (im < 0) ? longint'(-longint'(im)) : longint'(im);
        mag = floor_sqrt(are * are + aim * aim);
        pi_q = pi_fixed(0);
        half_q = pi_fixed(1);
        if (re == 0) begin
            ph = (im > 0) ? half_q : ((im == 0) ? 0 : -half_q);
        end
        else begin
            neg = (re < 0) != (im < 0);
            if (aim < are) begin
                term = rational_term(25 * are * aim, 25 * are * are + 7 * aim * aim);
                ph = neg ? -term : term;
                // Left half-plane: rotate by pi toward the sign of im.
                if (re < 0)
                    ph = (im < 0) ? ph - pi_q : ph + pi_q;
            end
            else begin
                term = rational_term(25 * are * aim, 25 * aim * aim + 7 * are * are);
                ph = half_q - (neg ? -term : term);
                if (im < 0)
                    ph = ph - pi_q;
            end
        end
        if (mag > 65535)
            mag = 65535;
        if (ph > 32767)
            ph = 32767;
        if (ph < -32768)
            ph = -32768;
        res.magnitude = mag[15:0];
        res.phase_angle = ph[15:0];
        return res;
    endfunction

    assign pending_count = polar_queue.size();

    always @(posedge clk) begin
        polar_t want;
        polar_t got;
        if (rst_n) begin
            if (s_tvalid && s_tready)
                polar_queue.push_back(to_polar(s_tdata[15:0], s_tdata[31:16]));
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (polar_queue.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result %h", m_tdata);
                end
                else begin
                    want = polar_queue.pop_front();
                    if (got.magnitude !== want.magnitude
                        || got.phase_angle !== want.phase_angle) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: expected mag %0d phase %0d, got mag %0d phase %0d",
                                     want.magnitude, want.phase_angle,
                                     got.magnitude, got.phase_angle);
                    end
                end
            end
        end
    end

    initial fail_count = 0;
endmodule

### dv/testbench.sv
// Top of the complex_magnitude_phase test: clock, reset, request stimulus,
// output stalls and the verdict. Depends on the block and cmp_checker.
`timescale 1ns / 1ps
module testbench;
    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    int          fail_count;
    int          pending_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_off_cycles;
    logic        hold_off_go;
    logic        hold_off_done;
    longint      cycle_count = 0;

    complex_magnitude_phase DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    cmp_checker polar_check (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Each request is offered at a clock edge and held until it is accepted.
    // Random idle cycles between requests follow send_idle_pct.
    task automatic send_sample(input logic [15:0] re, input logic [15:0] im);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {im, re};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Random samples lean on small values, axes and the diagonals now and then,
    // since branch edges of the phase approximation sit there.
    function automatic logic [15:0] pick_value();
        case ($urandom_range(5))
            0: return 16'($signed($urandom_range(16)) - 8);
            1: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Receiver: random stalls, plus one long hold-off so the pipe fills up.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
            hold_off_cycles <= 0;
            hold_off_done <= 1'b0;
        end
        else if (hold_off_go && !hold_off_done) begin
            m_tready <= 1'b0;
            hold_off_cycles <= 300;
            hold_off_done <= 1'b1;
        end
        else if (hold_off_cycles > 0) begin
            m_tready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Run limit: the slowest correct run is far below this.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] re;
        logic [15:0] im;
        logic [15:0] corner_vals[8];
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        send_idle_pct = 11;
        recv_idle_pct = 45;
        hold_off_go = 1'b0;
        corner_vals = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF,
                        16'h8000, 16'h8001, 16'h1234, 16'hEDCC};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Directed part: zero sample, axes in both directions, equal magnitudes
        // in all quadrants, negative real with zero imaginary, full-scale corners.
        send_sample(16'h0000, 16'h0000);
        send_sample(16'h0000, 16'h4000);
        send_sample(16'h0000, 16'hC000);
        send_sample(16'h8000, 16'h0000);
        send_sample(16'h7FFF, 16'h0000);
        send_sample(16'h1000, 16'h1000);
        send_sample(16'hF000, 16'h1000);
        send_sample(16'hF000, 16'hF000);
        send_sample(16'h1000, 16'hF000);
        send_sample(16'h8000, 16'h8000);
        send_sample(16'h7FFF, 16'h7FFF);
        send_sample(16'h8000, 16'h7FFF);
        send_sample(16'h7FFF, 16'h8000);
        send_sample(16'h0001, 16'h0002);
        send_sample(16'hFFFF, 16'hFFFE);
        for (int k = 0; k < 8; k++)
            send_sample(corner_vals[k], corner_vals[7 - k]);
        // Random part in three idling phases; the long hold-off falls in the first.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 11 : ((phase == 1) ? 45 : 0);
            recv_idle_pct = (phase == 0) ? 45 : ((phase == 1) ? 11 : 0);
            for (int n = 0; n < 530; n++) begin
                if (phase == 0 && n == 100)
                    hold_off_go <= 1'b1;
                re = pick_value();
                im = $urandom_range(7) == 0 ? re : pick_value();
                send_sample(re, im);
            end
        end
        s_tvalid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

### filelist.f
hw/rtl/cmp_pkg.sv
hw/rtl/cmp_sqrt.sv
hw/rtl/cmp_div.sv
hw/rtl/complex_magnitude_phase.sv
dv/cmp_checker.sv
dv/testbench.sv
